// File: rtl/tld_pkg.sv
// Shared constants, types and the name table of the telemetry line decoder.
package tld_pkg;

  localparam int unsigned LINE_LEN   = 14;
  localparam int unsigned CNT_W      = 4;
  localparam int unsigned VAL_BYTES  = 4;
  localparam int unsigned MAX_CPOS   = LINE_LEN - VAL_BYTES - 1;
  localparam int unsigned NAME_COUNT = 9;
  localparam int unsigned NAME_MAX   = 8;
  localparam int unsigned EXT_LEN    = MAX_CPOS + NAME_MAX;

  localparam logic [7:0] NEWLINE_BYTE = 8'h0A;
  localparam logic [7:0] COLON_BYTE   = 8'h3A;
  localparam logic [7:0] ON_BYTE      = 8'hAA;
  localparam logic [7:0] OFF_BYTE     = 8'h55;

  localparam logic [3:0] KIND_RESEND   = 4'd0;
  localparam logic [3:0] KIND_LED0     = 4'd1;
  localparam logic [3:0] KIND_LED1     = 4'd2;
  localparam logic [3:0] KIND_SWITCH0  = 4'd3;
  localparam logic [3:0] KIND_SWITCH1  = 4'd4;
  localparam logic [3:0] KIND_LOCTEMP  = 4'd5;
  localparam logic [3:0] KIND_POTMETER = 4'd6;
  localparam logic [3:0] KIND_REMTEMP  = 4'd7;
  localparam logic [3:0] KIND_LUX      = 4'd8;

  localparam logic [7:0] NAME_CHARS [NAME_COUNT][NAME_MAX] = '{
    '{"e", "r", "r", "o", "r", 8'h00, 8'h00, 8'h00},
    '{"l", "e", "d", "0", 8'h00, 8'h00, 8'h00, 8'h00},
    '{"l", "e", "d", "1", 8'h00, 8'h00, 8'h00, 8'h00},
    '{"s", "w", "i", "t", "c", "h", "0", 8'h00},
    '{"s", "w", "i", "t", "c", "h", "1", 8'h00},
    '{"l", "o", "c", "t", "e", "m", "p", 8'h00},
    '{"p", "o", "t", "m", "e", "t", "e", "r"},
    '{"r", "e", "m", "t", "e", "m", "p", 8'h00},
    '{"l", "u", "x", 8'h00, 8'h00, 8'h00, 8'h00, 8'h00}
  };

  localparam int unsigned NAME_LEN [NAME_COUNT] = '{5, 4, 4, 7, 7, 7, 8, 7, 3};

  localparam logic [3:0] NAME_KIND [NAME_COUNT] = '{
    KIND_RESEND, KIND_LED0, KIND_LED1, KIND_SWITCH0, KIND_SWITCH1,
    KIND_LOCTEMP, KIND_POTMETER, KIND_REMTEMP, KIND_LUX
  };

  typedef logic [LINE_LEN-1:0][7:0] line_t;

  typedef struct packed {
    logic        hit;
    logic [3:0]  kind;
    logic [31:0] value;
  } evt_t;

endpackage

// File: rtl/tld_decode.sv
// Combinational decode of one complete 14-byte line into an event.
module tld_decode (
  input  tld_pkg::line_t line_i,
  output tld_pkg::evt_t  evt_o
);
  import tld_pkg::*;

  // True when every flagged byte in [lo, hi) is whitespace.
  function automatic logic all_blank(logic [LINE_LEN-1:0] bl, int lo, int hi);
    logic ok;
    ok = 1'b1;
    for (int i = 0; i < LINE_LEN; i++) begin
      if (i >= lo && i < hi && !bl[i]) begin
        ok = 1'b0;
      end
    end
    return ok;
  endfunction

  logic [EXT_LEN-1:0][7:0]   ext;
  logic [LINE_LEN-1:0]       blank;
  logic [LINE_LEN-1:0]       colon;
  logic                      one_colon;
  logic [NAME_COUNT-1:0]     name_hit;
  logic                      nm;
  logic [VAL_BYTES-1:0][7:0] v;
  logic [31:0]               vword;
  logic                      all_on;
  logic                      all_off;
  logic [3:0]                kind;
  logic                      found;

  always_comb begin
    ext = '0;
    for (int i = 0; i < LINE_LEN; i++) begin
      ext[i]   = line_i[i];
      blank[i] = (line_i[i] == 8'h20) || (line_i[i] >= 8'h09 && line_i[i] <= 8'h0D);
      colon[i] = (line_i[i] == COLON_BYTE);
    end
    one_colon = ($countones(colon) == 1);

    // A name matches when it starts right after leading whitespace and only
    // whitespace lies between its end and the colon.
    name_hit = '0;
    nm       = 1'b0;
    for (int k = 0; k < NAME_COUNT; k++) begin
      for (int c = 0; c <= MAX_CPOS; c++) begin
        for (int s = 0; s <= MAX_CPOS; s++) begin
          if (s + NAME_LEN[k] <= c) begin
            nm = 1'b1;
            for (int j = 0; j < NAME_MAX; j++) begin
              if (j < NAME_LEN[k] && ext[s+j] != NAME_CHARS[k][j]) begin
                nm = 1'b0;
              end
            end
            if (colon[c] && nm && all_blank(blank, 0, s) &&
                all_blank(blank, s + NAME_LEN[k], c)) begin
              name_hit[k] = 1'b1;
            end
          end
        end
      end
    end

    v = '0;
    for (int c = 0; c <= MAX_CPOS; c++) begin
      if (colon[c]) begin
        for (int j = 0; j < VAL_BYTES; j++) begin
          v[j] = line_i[c+1+j];
        end
      end
    end
    vword   = {v[3], v[2], v[1], v[0]};
    all_on  = (v[0] == ON_BYTE) && (v[1] == ON_BYTE) && (v[2] == ON_BYTE) &&
              (v[3] == ON_BYTE);
    all_off = (v[0] == OFF_BYTE) && (v[1] == OFF_BYTE) && (v[2] == OFF_BYTE) &&
              (v[3] == OFF_BYTE);

    kind  = KIND_RESEND;
    found = 1'b0;
    for (int k = NAME_COUNT - 1; k >= 0; k--) begin
      if (name_hit[k]) begin
        kind  = NAME_KIND[k];
        found = 1'b1;
      end
    end

    evt_o.kind  = kind;
    evt_o.hit   = 1'b0;
    evt_o.value = '0;
    if (found && one_colon) begin
      if (kind == KIND_RESEND) begin
        evt_o.hit = 1'b1;
      end else if (kind <= KIND_SWITCH1) begin
        evt_o.hit   = all_on || all_off;
        evt_o.value = {31'd0, all_on};
      end else begin
        evt_o.hit   = 1'b1;
        evt_o.value = vword;
      end
    end
  end

endmodule

// File: rtl/telemetry_line_decoder.sv
// Telemetry line decoder: collects received bytes into lines and emits one event per valid line.
// One byte item is taken every clock cycle while input ready is high. The first 13 bytes of a
// line sit in a byte store; the byte that closes a full line is joined with them into a line
// register, and the name and value decode runs between that register and the output register.
// A newline before the 14th byte drops the line. Input ready falls only while the line register
// holds a full line that the stalled output register cannot yet take.
module telemetry_line_decoder (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [7:0]  in_tdata,   // [7:0] rx_byte
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [39:0] out_tdata   // [3:0] event_kind, [35:4] event_value, [39:36] zero
);
  import tld_pkg::*;

  logic [7:0]       line_store_r [LINE_LEN-1];
  logic [CNT_W-1:0] line_count_r;
  logic [CNT_W-1:0] line_count_nxt;
  logic             s1_valid_r;
  logic             s1_valid_nxt;
  line_t            s1_line_r;
  logic             out_valid_r;
  logic             out_valid_nxt;
  logic [3:0]       out_kind_r;
  logic [31:0]      out_value_r;
  logic             in_acc;
  logic             out_free;
  logic             close_full;
  evt_t             evt;

  assign out_free   = !out_valid_r || out_tready;
  assign in_tready  = !s1_valid_r || out_free;
  assign in_acc     = in_tvalid && in_tready;
  assign close_full = (line_count_r == CNT_W'(LINE_LEN - 1));

  always_comb begin
    line_count_nxt = line_count_r;
    if (in_acc) begin
      if (close_full || in_tdata == NEWLINE_BYTE) begin
        line_count_nxt = '0;
      end else begin
        line_count_nxt = line_count_r + 1'b1;
      end
    end
    s1_valid_nxt = (s1_valid_r && !out_free) || (in_acc && close_full);
    out_valid_nxt = out_free ? (s1_valid_r && evt.hit) : out_valid_r;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      line_count_r <= '0;
      s1_valid_r   <= 1'b0;
      out_valid_r  <= 1'b0;
    end else begin
      line_count_r <= line_count_nxt;
      s1_valid_r   <= s1_valid_nxt;
      out_valid_r  <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (in_acc && !close_full) begin
      line_store_r[line_count_r] <= in_tdata;
    end
    if (in_acc && close_full) begin
      for (int i = 0; i < LINE_LEN - 1; i++) begin
        s1_line_r[i] <= line_store_r[i];
      end
      s1_line_r[LINE_LEN-1] <= in_tdata;
    end
    if (out_free) begin
      out_kind_r  <= evt.kind;
      out_value_r <= evt.value;
    end
  end

  tld_decode u_decode (
    .line_i (s1_line_r),
    .evt_o  (evt)
  );

  assign out_tvalid = out_valid_r;
  assign out_tdata  = {4'd0, out_value_r, out_kind_r};

  a_count_range: assert property (@(posedge clk) disable iff (!rst_n)
    line_count_r <= CNT_W'(LINE_LEN - 1))
    else $error("line count beyond the line length");

  a_full_line_staged: assert property (@(posedge clk) disable iff (!rst_n)
    (in_acc && close_full) |=> s1_valid_r)
    else $error("full line not held in the line register");

  a_no_overrun: assert property (@(posedge clk) disable iff (!rst_n)
    (s1_valid_r && out_valid_r && !out_tready) |-> !in_tready)
    else $error("input taken while the line register is blocked");

  a_out_from_line: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid_r) |-> $past(s1_valid_r))
    else $error("event raised without a staged line");

endmodule

// File: verif/telemetry_line_decoder_tb.sv
`timescale 1ns / 1ps
// Self-checking testbench for the telemetry line decoder: byte stream stimulus and event checks.
module telemetry_line_decoder_tb;
  import tld_pkg::*;

  localparam int unsigned WATCHDOG_LIMIT = 2000;
  localparam int unsigned RANDOM_BYTES   = 1700;
  localparam int unsigned DRAIN_CYCLES   = 8;

  typedef struct packed {
    logic [3:0]  kind;
    logic [31:0] value;
  } tele_event_t;

  // Tracks the open line, decodes each closed line and holds the events still to come out.
  class line_scoreboard;
    logic [7:0]    line_bytes [LINE_LEN];
    int unsigned   fill;
    tele_event_t   pending [$];
    int unsigned   errors;

    function new();
      fill = 0;
      errors = 0;
    endfunction

    function bit is_blank(logic [7:0] c);
      return c == 8'h20 || (c >= 8'h09 && c <= 8'h0D);
    endfunction

    function bit name_is(int first, int last, string nm);
      if (last - first != nm.len()) return 0;
      for (int i = 0; i < nm.len(); i++) begin
        if (line_bytes[first + i] != nm[i]) return 0;
      end
      return 1;
    endfunction

    function void note_byte(logic [7:0] b);
      int          colons;
      int          cpos;
      int          first;
      int          last;
      logic [3:0]  kind;
      logic [7:0]  v0, v1, v2, v3;
      tele_event_t ev;
      line_bytes[fill] = b;
      fill++;
      if (b != NEWLINE_BYTE && fill < LINE_LEN) return;
      if (fill != LINE_LEN) begin
        fill = 0;
        return;
      end
      fill = 0;
      colons = 0;
      cpos = 0;
      for (int i = 0; i < LINE_LEN; i++) begin
        if (line_bytes[i] == COLON_BYTE) begin
          colons++;
          cpos = i;
        end
      end
      if (colons != 1 || cpos > int'(LINE_LEN) - 5) return;
      first = 0;
      last = cpos;
      while (first < last && is_blank(line_bytes[first])) first++;
      while (last > first && is_blank(line_bytes[last - 1])) last--;
      if (name_is(first, last, "error")) kind = KIND_RESEND;
      else if (name_is(first, last, "led0")) kind = KIND_LED0;
      else if (name_is(first, last, "led1")) kind = KIND_LED1;
      else if (name_is(first, last, "switch0")) kind = KIND_SWITCH0;
      else if (name_is(first, last, "switch1")) kind = KIND_SWITCH1;
      else if (name_is(first, last, "loctemp")) kind = KIND_LOCTEMP;
      else if (name_is(first, last, "potmeter")) kind = KIND_POTMETER;
      else if (name_is(first, last, "remtemp")) kind = KIND_REMTEMP;
      else if (name_is(first, last, "lux")) kind = KIND_LUX;
      else return;
      v0 = line_bytes[cpos + 1];
      v1 = line_bytes[cpos + 2];
      v2 = line_bytes[cpos + 3];
      v3 = line_bytes[cpos + 4];
      ev.kind = kind;
      if (kind == KIND_RESEND) begin
        ev.value = 32'd0;
      end else if (kind <= KIND_SWITCH1) begin
        if (v0 == ON_BYTE && v1 == ON_BYTE && v2 == ON_BYTE && v3 == ON_BYTE) begin
          ev.value = 32'd1;
        end else if (v0 == OFF_BYTE && v1 == OFF_BYTE && v2 == OFF_BYTE && v3 == OFF_BYTE) begin
          ev.value = 32'd0;
        end else begin
          return;
        end
      end else begin
        ev.value = {v3, v2, v1, v0};
      end
      pending.push_back(ev);
    endfunction

    function void check_event(logic [39:0] data);
      tele_event_t want;
      if (pending.size() == 0) begin
        $error("event with nothing expected: event_kind %0d event_value 0x%08h",
               data[3:0], data[35:4]);
        errors++;
        return;
      end
      want = pending.pop_front();
      if (data[3:0] !== want.kind) begin
        $error("event_kind mismatch: expected %0d, actual %0d", want.kind, data[3:0]);
        errors++;
      end
      if (data[35:4] !== want.value) begin
        $error("event_value mismatch: expected 0x%08h, actual 0x%08h", want.value, data[35:4]);
        errors++;
      end
    endfunction
  endclass

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        in_tvalid = 1'b0;
  logic        in_tready;
  logic [7:0]  in_tdata = 8'h00;
  logic        out_tvalid;
  logic        out_tready = 1'b0;
  logic [39:0] out_tdata;

  line_scoreboard sb = new();
  int unsigned    send_idle = 0;
  int unsigned    recv_idle = 0;
  int unsigned    bytes_sent = 0;
  int unsigned    quiet_cycles = 0;
  logic [7:0]     line_q [$];

  telemetry_line_decoder u_dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata)
  );

  initial begin
    forever #5 clk = ~clk;
  end

  always @(posedge clk) begin
    if (!rst_n) begin
      out_tready <= 1'b0;
    end else begin
      out_tready <= ($urandom_range(0, 99) >= recv_idle);
    end
  end

  always @(posedge clk) begin
    if (rst_n && out_tvalid && out_tready) sb.check_event(out_tdata);
  end

  always @(posedge clk) begin
    if (!rst_n || (in_tvalid && in_tready) || (out_tvalid && out_tready)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= WATCHDOG_LIMIT) begin
      $display("FAILURE");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  task automatic send_byte(input logic [7:0] b);
    while ($urandom_range(0, 99) < send_idle) begin
      in_tvalid <= 1'b0;
      @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata <= b;
    @(posedge clk);
    while (!in_tready) @(posedge clk);
    sb.note_byte(b);
    bytes_sent++;
  endtask

  task automatic send_queue();
    foreach (line_q[i]) send_byte(line_q[i]);
    line_q.delete();
  endtask

  function automatic void push_text(string s);
    for (int i = 0; i < s.len(); i++) line_q.push_back(s[i]);
  endfunction

  function automatic logic [7:0] blank_byte();
    case ($urandom_range(0, 4))
      0: return 8'h20;
      1: return 8'h09;
      2: return 8'h0B;
      3: return 8'h0C;
      default: return 8'h0D;
    endcase
  endfunction

  // Any byte that neither closes the line nor adds a colon.
  function automatic logic [7:0] plain_byte();
    logic [7:0] b;
    do b = $urandom_range(0, 255); while (b == NEWLINE_BYTE || b == COLON_BYTE);
    return b;
  endfunction

  function automatic string name_text(int k);
    case (k)
      0: return "error";
      1: return "led0";
      2: return "led1";
      3: return "switch0";
      4: return "switch1";
      5: return "loctemp";
      6: return "potmeter";
      7: return "remtemp";
      8: return "lux";
      default: begin
        case ($urandom_range(0, 4))
          0: return "lux0";
          1: return "led";
          2: return "switch";
          3: return "temp";
          default: return "errorx";
        endcase
      end
    endcase
  endfunction

  // Builds one full-length report line: padded name, colon, value bytes, filler.
  function automatic void build_report_line();
    string      nm;
    int         k;
    int         budget;
    int         lead;
    int         trail;
    int         name_at;
    int         roll;
    int         pattern;
    logic [7:0] vb;
    logic [7:0] frame [$];
    k = $urandom_range(0, 9);
    nm = name_text(k);
    budget = 9 - nm.len();
    // Sometimes push the colon so far right that the value is cut short.
    if ($urandom_range(0, 99) < 15) budget = 13 - nm.len();
    lead = $urandom_range(0, budget);
    trail = $urandom_range(0, budget - lead);
    repeat (lead) frame.push_back(blank_byte());
    name_at = frame.size();
    for (int i = 0; i < nm.len(); i++) frame.push_back(nm[i]);
    repeat (trail) frame.push_back(blank_byte());
    roll = $urandom_range(0, 99);
    if (roll < 6) begin
      frame[name_at + $urandom_range(0, nm.len() - 1)] = $urandom_range(0, 255);
    end else if (roll < 10) begin
      frame[name_at + $urandom_range(0, nm.len() - 1)] = blank_byte();
    end
    frame.push_back(COLON_BYTE);
    pattern = $urandom_range(0, 99);
    for (int i = 0; i < 4 && frame.size() < LINE_LEN; i++) begin
      if (k >= 1 && k <= 4) begin
        if (pattern < 40) vb = ON_BYTE;
        else if (pattern < 80) vb = OFF_BYTE;
        else if ($urandom_range(0, 2) == 0) vb = $urandom_range(0, 255);
        else vb = $urandom_range(0, 1) ? ON_BYTE : OFF_BYTE;
      end else begin
        vb = $urandom_range(0, 255);
      end
      if (frame.size() < LINE_LEN - 1 && (vb == NEWLINE_BYTE || vb == COLON_BYTE) &&
          $urandom_range(0, 9) != 0) begin
        vb = plain_byte();
      end
      frame.push_back(vb);
    end
    while (frame.size() < LINE_LEN - 1) begin
      frame.push_back(($urandom_range(0, 99) < 4) ? COLON_BYTE : plain_byte());
    end
    if (frame.size() < LINE_LEN) begin
      frame.push_back($urandom_range(0, 1) ? NEWLINE_BYTE : plain_byte());
    end
    foreach (frame[i]) line_q.push_back(frame[i]);
  endfunction

  initial begin
    int unsigned goal;
    int          sel;
    int          n;
    repeat (2) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Directed lines: a bare newline, a trimmed resend request closed by its newline,
    // an all-ones value, an on switch, and a value cut short by a late colon.
    line_q.push_back(NEWLINE_BYTE);
    line_q.push_back(8'h09);
    push_text("error");
    line_q.push_back(8'h0D);
    line_q.push_back(COLON_BYTE);
    line_q.push_back(8'h00);
    line_q.push_back(8'hFF);
    line_q.push_back(8'h00);
    line_q.push_back(8'hFF);
    line_q.push_back(8'h7F);
    line_q.push_back(NEWLINE_BYTE);
    push_text("potmeter:");
    repeat (4) line_q.push_back(8'hFF);
    line_q.push_back(8'h00);
    push_text(" led0 :");
    repeat (4) line_q.push_back(ON_BYTE);
    line_q.push_back(8'h80);
    line_q.push_back(8'h01);
    line_q.push_back(NEWLINE_BYTE);
    push_text("   remtemp :a");
    line_q.push_back(NEWLINE_BYTE);
    send_queue();

    for (int phase = 0; phase < 3; phase++) begin
      send_idle = (phase == 0) ? 31 : (phase == 1) ? 87 : 0;
      recv_idle = (phase == 0) ? 87 : (phase == 1) ? 31 : 0;
      goal = bytes_sent + RANDOM_BYTES / 3;
      while (bytes_sent < goal) begin
        sel = $urandom_range(0, 99);
        if (sel < 75) begin
          if (sb.fill != 0) line_q.push_back(NEWLINE_BYTE);
          build_report_line();
        end else if (sel < 88) begin
          n = $urandom_range(0, 12);
          repeat (n) line_q.push_back(plain_byte());
          line_q.push_back(NEWLINE_BYTE);
        end else begin
          n = $urandom_range(1, 20);
          repeat (n) line_q.push_back($urandom_range(0, 255));
        end
        send_queue();
      end
    end

    in_tvalid <= 1'b0;
    while (sb.pending.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (sb.errors == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

endmodule

// File: files.f
rtl/tld_pkg.sv
rtl/tld_decode.sv
rtl/telemetry_line_decoder.sv
verif/telemetry_line_decoder_tb.sv
